/* src/text_terminal_cursor_scroll_macros.svh */
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcs check failed");

// next-cycle implication, checked on every rising edge outside reset
`define TCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcs check failed");

`endif

/* src/tcs_pkg.sv */
`timescale 1ns / 1ps

package tcs_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // fixed field widths
  localparam int ADDR_IN_W = 11;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = 16;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  // function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // character and attribute constants
  localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h04;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    make_cell = {attr, ch};
  endfunction

  localparam logic [CELL_W-1:0] BLANK_CELL = {RESET_COLOR, BLANK_CHAR};

  // result word handed from the controller to the output register
  typedef struct packed {
    logic [CELL_W-1:0]    read_entry;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic                 scrolled;
  } tcs_res_t;

endpackage

/* src/tcs_cmd_if.sv */
`timescale 1ns / 1ps

interface tcs_cmd_if
  import tcs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [CHAR_W-1:0]    char_code;
  logic [ADDR_IN_W-1:0] read_address;

  modport source (output valid, output func, output char_code, output read_address,
                  input ready);
  modport sink   (input valid, input func, input char_code, input read_address,
                  output ready);
endinterface

/* src/tcs_rsp_if.sv */
`timescale 1ns / 1ps

interface tcs_rsp_if
  import tcs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CELL_W-1:0]    read_entry;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic                 scrolled;

  modport source (output valid, output read_entry, output cursor_col, output cursor_row,
                  output scrolled, input ready);
  modport sink   (input valid, input read_entry, input cursor_col, input cursor_row,
                  input scrolled, output ready);
endinterface

/* src/tcs_cell_ram.sv */
`timescale 1ns / 1ps

module tcs_cell_ram
  import tcs_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tcs_ctrl.sv */
`timescale 1ns / 1ps

`include "text_terminal_cursor_scroll_macros.svh"

module tcs_ctrl
  import tcs_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int AW      = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic              clk,
  input  logic              rst,
  tcs_cmd_if.sink           cmd,
  input  logic [ATTR_W-1:0] text_color,
  output logic              res_valid,
  input  logic              res_ready,
  output tcs_res_t          res,
  output logic              color_rst,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int SW    = ((AW > ADDR_IN_W) ? AW : ADDR_IN_W) + 1;
  // row = addr / COLUMNS by reciprocal, exact for all 11-bit addresses
  localparam int K     = ADDR_IN_W + $clog2(COLUMNS);
  localparam int MW    = ADDR_IN_W + 2;
  localparam int PW    = ADDR_IN_W + MW + RW;
  localparam logic [MW-1:0] RECIP = MW'(((1 << K) + COLUMNS - 1) / COLUMNS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_RCHK  = 3'd2;
  localparam logic [2:0] S_RWAIT = 3'd3;
  localparam logic [2:0] S_PCHK  = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]           state;
  logic [CHAR_W-1:0]    char_q;
  logic [ADDR_IN_W-1:0] addr_q;
  logic [RW-1:0]        row_q;
  logic [AW-1:0]        paddr_q;
  logic [CELL_W-1:0]    entry;
  logic                 scrolled;
  logic [CW-1:0]        clr_cnt;

  // cursor, logical and physical; top is the physical row shown as row 0
  logic [CW-1:0]        cur_col;
  logic [RW-1:0]        cur_row;
  logic [RW-1:0]        cur_prow;
  logic [AW-1:0]        cur_pbase;
  logic [RW-1:0]        top;
  logic [AW-1:0]        top_base;
  logic [ROWS-1:0]      row_valid;

  logic [CW-1:0]        cur_col_next;
  logic [RW-1:0]        cur_row_next;
  logic [RW-1:0]        cur_prow_next;
  logic [AW-1:0]        cur_pbase_next;
  logic [RW-1:0]        top_next;
  logic [AW-1:0]        top_base_next;
  logic                 do_scroll;

  logic [PW-1:0]        prod;
  logic [SW-1:0]        psum;
  logic [RW:0]          prow_sum;
  logic [RW-1:0]        prow;
  logic [CW:0]          col_inc;
  logic                 line_end;
  logic [SW-1:0]        pbase_sum;
  logic [SW-1:0]        tbase_sum;
  logic [RW:0]          prow_inc;
  logic [RW:0]          top_inc;

  assign cmd.ready = (state == S_IDLE);

  // address split for reads: logical row, then physical cell through the ring
  always_comb begin
    prod     = PW'(addr_q) * PW'(RECIP);
    psum     = SW'(addr_q) + SW'(top_base);
    if (psum >= SW'(CELLS)) begin
      psum = psum - SW'(CELLS);
    end
    prow_sum = (RW+1)'(row_q) + (RW+1)'(top);
    if (prow_sum >= (RW+1)'(ROWS)) begin
      prow_sum = prow_sum - (RW+1)'(ROWS);
    end
    prow = prow_sum[RW-1:0];
  end

  // cursor advance after a put, with scroll through the row ring
  always_comb begin
    col_inc   = (CW+1)'(cur_col) + (CW+1)'(1);
    line_end  = (col_inc == (CW+1)'(COLUMNS)) || (char_q == NEWLINE_CHAR);
    pbase_sum = SW'(cur_pbase) + SW'(COLUMNS);
    if (pbase_sum >= SW'(CELLS)) begin
      pbase_sum = pbase_sum - SW'(CELLS);
    end
    tbase_sum = SW'(top_base) + SW'(COLUMNS);
    if (tbase_sum >= SW'(CELLS)) begin
      tbase_sum = tbase_sum - SW'(CELLS);
    end
    prow_inc = (RW+1)'(cur_prow) + (RW+1)'(1);
    if (prow_inc >= (RW+1)'(ROWS)) begin
      prow_inc = '0;
    end
    top_inc = (RW+1)'(top) + (RW+1)'(1);
    if (top_inc >= (RW+1)'(ROWS)) begin
      top_inc = '0;
    end

    cur_col_next   = col_inc[CW-1:0];
    cur_row_next   = cur_row;
    cur_prow_next  = cur_prow;
    cur_pbase_next = cur_pbase;
    top_next       = top;
    top_base_next  = top_base;
    do_scroll      = 1'b0;
    if (line_end) begin
      cur_col_next = '0;
      if (cur_row == RW'(ROWS - 1)) begin
        // old top row is recycled as the new bottom row
        do_scroll      = 1'b1;
        top_next       = top_inc[RW-1:0];
        top_base_next  = AW'(tbase_sum);
        cur_prow_next  = top;
        cur_pbase_next = top_base;
      end else begin
        cur_row_next   = cur_row + RW'(1);
        cur_prow_next  = prow_inc[RW-1:0];
        cur_pbase_next = AW'(pbase_sum);
      end
    end
  end

  // memory access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_pbase + AW'(cur_col);
    ram_wdata = make_cell(char_q, text_color);
    ram_re    = 1'b0;
    ram_raddr = paddr_q;
    color_rst = 1'b0;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_pbase + AW'(clr_cnt);
        ram_wdata = BLANK_CELL;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        color_rst = do_scroll;
      end
      S_RCHK: begin
        ram_re = row_valid[prow];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_prow  <= '0;
      cur_pbase <= '0;
      top       <= '0;
      top_base  <= '0;
      row_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            char_q   <= cmd.char_code;
            addr_q   <= cmd.read_address;
            scrolled <= 1'b0;
            if (cmd.func == FUNC_PUT) begin
              state <= S_PCHK;
            end else if (SW'(cmd.read_address) >= SW'(CELLS)) begin
              entry <= '0;
              state <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          row_q   <= prod[K +: RW];
          paddr_q <= AW'(psum);
          state   <= S_RCHK;
        end
        S_RCHK: begin
          if (row_valid[prow]) begin
            state <= S_RWAIT;
          end else begin
            entry <= BLANK_CELL;
            state <= S_FIN;
          end
        end
        S_RWAIT: begin
          entry <= ram_rdata;
          state <= S_FIN;
        end
        S_PCHK: begin
          clr_cnt <= '0;
          state   <= row_valid[cur_prow] ? S_PUT : S_CLR;
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(COLUMNS - 1)) begin
            row_valid[cur_prow] <= 1'b1;
            state               <= S_PUT;
          end
        end
        S_PUT: begin
          entry     <= '0;
          scrolled  <= do_scroll;
          cur_col   <= cur_col_next;
          cur_row   <= cur_row_next;
          cur_prow  <= cur_prow_next;
          cur_pbase <= cur_pbase_next;
          top       <= top_next;
          top_base  <= top_base_next;
          if (do_scroll) begin
            row_valid[top] <= 1'b0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word
  assign res_valid      = (state == S_FIN);
  assign res.read_entry = entry;
  assign res.cursor_col = COL_OUT_W'(cur_col);
  assign res.cursor_row = ROW_OUT_W'(cur_row);
  assign res.scrolled   = scrolled;

  // checks
  `TCS_ASSERT_IMPL(a_prow_ring, clk, rst, 1'b1, (int'(cur_row) + int'(top) == int'(cur_prow)) || (int'(cur_row) + int'(top) == int'(cur_prow) + ROWS))
  `TCS_ASSERT_IMPL(a_pbase_match, clk, rst, 1'b1, int'(cur_pbase) == int'(cur_prow) * COLUMNS)
  `TCS_ASSERT_NEXT(a_scroll_drops_row, clk, rst, color_rst, !row_valid[$past(top)])
  `TCS_ASSERT_IMPL(a_write_states, clk, rst, ram_we, (state == S_PUT) || (state == S_CLR))

endmodule

/* src/text_terminal_cursor_scroll.sv */
`timescale 1ns / 1ps

// Text terminal of COLUMNS x ROWS cells held in one single-port-write cell RAM that
// is used as a ring of rows: a scroll moves the top-row pointer and drops one row,
// so it costs no copying. Each row has a valid bit; a row not yet written since
// reset or since it was scrolled off reads as a blank in attribute 0x04, and the
// first put into it sweeps it blank first, one cell per cycle. Items are worked
// one at a time: a put checks the row, sweeps it if needed, writes the cell and
// passes its result on; a read divides by COLUMNS, looks up the ring, reads the
// RAM and passes its result on, with the RAM read skipped when its row still
// reads blank and straight to the result when the address is past the screen.
// A result waits in an output register, so the next word is taken while the
// previous result is still pending. A scroll also sets text_color back to 0x04.
// text_color may be written only while the block is idle.
module text_terminal_cursor_scroll
  import tcs_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  tcs_cmd_if.sink           cmd,
  tcs_rsp_if.source         rsp,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [ATTR_W-1:0] text_color;
  logic              color_rst;
  logic              res_valid;
  logic              res_ready;
  tcs_res_t          res;
  logic              out_valid;
  tcs_res_t          out_data;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // color register, reloaded to the reset color on scroll
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end else if (color_rst) begin
      text_color <= RESET_COLOR;
    end
  end

  tcs_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .text_color (text_color),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .color_rst  (color_rst),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  tcs_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_entry = out_data.read_entry;
  assign rsp.cursor_col = out_data.cursor_col;
  assign rsp.cursor_row = out_data.cursor_row;
  assign rsp.scrolled   = out_data.scrolled;

endmodule

/* verif/tcs_screen_checker.sv */
`timescale 1ns / 1ps

module tcs_screen_checker
  import tcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  tcs_cmd_if                cmd,
  tcs_rsp_if                rsp,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata,
  output int                words_due,
  output int                fail_count
);

  localparam int CELLS = DEF_COLUMNS * DEF_ROWS;

  // shadow copy of the screen, cursor and attribute
  logic [CELL_W-1:0]    screen_mem [CELLS];
  logic [COL_OUT_W-1:0] cur_col;
  logic [ROW_OUT_W-1:0] cur_row;
  logic [ATTR_W-1:0]    color_reg;
  tcs_res_t             results_due [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // screen scrolls up one row, bottom row goes blank in the reset color
  task automatic scroll_screen();
    int i;
    for (i = 0; i < CELLS - DEF_COLUMNS; i++) begin
      screen_mem[i] = screen_mem[i + DEF_COLUMNS];
    end
    for (i = CELLS - DEF_COLUMNS; i < CELLS; i++) begin
      screen_mem[i] = BLANK_CELL;
    end
    color_reg = RESET_COLOR;
  endtask

  // apply one word to the shadow screen and work out its result
  task automatic apply_word(input logic fn, input logic [CHAR_W-1:0] ch,
                            input logic [ADDR_IN_W-1:0] addr, output tcs_res_t res);
    int pos;
    res = '0;
    if (fn == FUNC_READ) begin
      if (int'(addr) < CELLS) res.read_entry = screen_mem[addr];
    end else begin
      // the byte is stored even when it is a newline
      pos = int'(cur_row) * DEF_COLUMNS + int'(cur_col);
      screen_mem[pos] = {color_reg, ch};
      if (int'(cur_col) + 1 >= DEF_COLUMNS || ch == NEWLINE_CHAR) begin
        cur_col = '0;
        if (int'(cur_row) == DEF_ROWS - 1) begin
          scroll_screen();
          res.scrolled = 1'b1;
        end else begin
          cur_row = cur_row + 1'b1;
        end
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end
    res.cursor_col = cur_col;
    res.cursor_row = cur_row;
  endtask

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    tcs_res_t want;
    tcs_res_t got;
    if (rst) begin
      foreach (screen_mem[i]) screen_mem[i] = BLANK_CELL;
      cur_col    = '0;
      cur_row    = '0;
      color_reg  = RESET_COLOR;
      fail_count = 0;
      results_due.delete();
      words_due <= 0;
    end else begin
      if (cfg_we) color_reg = cfg_wdata;

      // compare an accepted result with the oldest one due
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no word due", rsp.read_entry, 0);
        end else begin
          want = results_due.pop_front();
          if (rsp.read_entry !== want.read_entry)
            report_mismatch("read_entry", rsp.read_entry, want.read_entry);
          if (rsp.cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", rsp.cursor_col, want.cursor_col);
          if (rsp.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", rsp.cursor_row, want.cursor_row);
          if (rsp.scrolled !== want.scrolled)
            report_mismatch("scrolled", rsp.scrolled, want.scrolled);
        end
      end

      // predict the result of an accepted word
      if (cmd.valid && cmd.ready) begin
        apply_word(cmd.func, cmd.char_code, cmd.read_address, got);
        results_due.push_back(got);
      end
      words_due <= results_due.size();
    end
  end

endmodule

/* verif/tb_text_terminal_cursor_scroll.sv */
`timescale 1ns / 1ps

module tb_text_terminal_cursor_scroll;
  import tcs_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SEGMENTS    = 12;
  localparam int SEG_WORDS   = 110;
  localparam int CELLS       = DEF_COLUMNS * DEF_ROWS;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                words_due;
  int                fail_count;
  int                quiet_cycles = 0;

  tcs_cmd_if cmd_ch();
  tcs_rsp_if rsp_ch();

  text_terminal_cursor_scroll dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcs_screen_checker screen_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .words_due  (words_due),
    .fail_count (fail_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side stalls at random
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one word after a random gap and hold it until taken
  task automatic send_word(input logic fn, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_IN_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.func         <= fn;
    cmd_ch.char_code    <= ch;
    cmd_ch.read_address <= addr;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_word(FUNC_PUT, ch, ADDR_IN_W'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input int addr);
    send_word(FUNC_READ, CHAR_W'($urandom_range(0, 255)), ADDR_IN_W'(addr));
  endtask

  // wait until every result has come back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  task automatic set_color(input logic [ATTR_W-1:0] color);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly printable text, with frequent newlines and some raw bytes
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return NEWLINE_CHAR;
    else if (r < 25) return CHAR_W'($urandom_range(0, 255));
    else return CHAR_W'($urandom_range(8'h21, 8'h7e));
  endfunction

  // random text with reads spread over the screen and past it
  task automatic run_segment(input int n);
    int sent;
    int r;
    int i;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 1) begin
        // one full line without a newline wraps the column
        for (i = 0; i < DEF_COLUMNS; i++) put_char(CHAR_W'($urandom_range(8'h21, 8'h7e)));
        sent += DEF_COLUMNS;
      end else begin
        if (r < 70) put_char(pick_char());
        else if (r < 80) read_cell($urandom_range(CELLS - DEF_COLUMNS, CELLS - 1));
        else if (r < 95) read_cell($urandom_range(0, CELLS - 1));
        else read_cell($urandom_range(CELLS, 2047));
        sent++;
      end
    end
  endtask

  initial begin
    int seg;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.func         = FUNC_PUT;
    cmd_ch.char_code    = '0;
    cmd_ch.read_address = '0;
    rsp_ch.ready        = 1'b0;
    send_idle_pct       = 6;
    recv_idle_pct       = 58;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, address extremes, byte extremes, newline
    set_color(8'h00);
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2047);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(NEWLINE_CHAR);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    put_char(8'h41);
    read_cell(DEF_COLUMNS);
    read_cell(DEF_COLUMNS + 1);
    read_cell(2 * DEF_COLUMNS);
    set_color(8'h5A);
    put_char(BLANK_CHAR);
    read_cell(DEF_COLUMNS + 1);
    read_cell(1);

    // random segments, each under a fresh color
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 6;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 0) set_color(8'hFF);
      else if (seg == SEGMENTS - 1) set_color(8'h00);
      else set_color(ATTR_W'($urandom_range(0, 255)));
      run_segment(SEG_WORDS);
    end

    drain();
    repeat (2 * (DEF_COLUMNS + 5)) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/tcs_pkg.sv
src/tcs_cmd_if.sv
src/tcs_rsp_if.sv
src/tcs_cell_ram.sv
src/tcs_ctrl.sv
src/text_terminal_cursor_scroll.sv
verif/tcs_screen_checker.sv
verif/tb_text_terminal_cursor_scroll.sv
